@@ hdl/lptr_pkg.sv @@
// shared types, constants and register map of the loss plateau and ravine tracker
`default_nettype none

package lptr_pkg;

    localparam int LOSS_W   = 31;
    localparam int VEL_W    = 32;
    localparam int RADIUS_W = 16;
    localparam int COUNT_W  = 16;
    localparam int DIR_W    = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_ONE  = 16'd16384;
    localparam logic [RADIUS_W-1:0] RADIUS_KICK = 16'd32768;
    localparam logic [COUNT_W-1:0]  COUNT_MAX   = 16'hFFFF;

    localparam logic [LOSS_W-1:0]   FLAT_THRESHOLD_RST = 31'd1678;
    localparam logic [COUNT_W-1:0]  STUCK_LIMIT_RST    = 16'd8;
    localparam logic [15:0]         SHRINK_FACTOR_RST  = 16'd62259;

    // register indexes, byte address 4*index
    localparam logic [1:0] REG_FLAT_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_STUCK_LIMIT    = 2'd1;
    localparam logic [1:0] REG_SHRINK_FACTOR  = 2'd2;

    typedef struct packed {
        logic [LOSS_W-1:0] loss;
        logic [DIR_W-1:0]  direction;
    } in_req_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic                ravine_flag;
        logic [COUNT_W-1:0]  stuck_count;
        logic [VEL_W-1:0]    velocity;
        logic [LOSS_W-1:0]   change_average;
        logic [DIR_W-1:0]    latched_direction;
    } out_req_t;

    typedef struct packed {
        logic [LOSS_W-1:0]  flat_threshold;
        logic [COUNT_W-1:0] stuck_limit;
        logic [15:0]        shrink_factor;
    } cfg_t;

    // front stage result handed to the recurrence stage
    typedef struct packed {
        logic [LOSS_W-1:0] abs_change;
        logic [VEL_W-1:0]  velocity;
        logic              falling;
        logic              first;
        logic [DIR_W-1:0]  direction;
    } stage_t;

endpackage

`default_nettype wire

@@ hdl/lptr_regs.sv @@
// configuration register file with apb-style access
`default_nettype none

module lptr_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lptr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lptr_pkg::DATA_W-1:0] pwdata,
    output logic      [lptr_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output lptr_pkg::cfg_t                   cfg
);
    import lptr_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] index;
    logic       wr_en;

    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flat_threshold <= FLAT_THRESHOLD_RST;
            cfg_reg.stuck_limit    <= STUCK_LIMIT_RST;
            cfg_reg.shrink_factor  <= SHRINK_FACTOR_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_FLAT_THRESHOLD: cfg_reg.flat_threshold <= pwdata[LOSS_W-1:0];
                REG_STUCK_LIMIT:    cfg_reg.stuck_limit    <= pwdata[COUNT_W-1:0];
                REG_SHRINK_FACTOR:  cfg_reg.shrink_factor  <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_FLAT_THRESHOLD: prdata = {1'b0, cfg_reg.flat_threshold};
            REG_STUCK_LIMIT:    prdata = {16'd0, cfg_reg.stuck_limit};
            REG_SHRINK_FACTOR:  prdata = {16'd0, cfg_reg.shrink_factor};
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/lptr_front.sv @@
// input stage: loss difference against the previous sample, input register
`default_nettype none

module lptr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lptr_pkg::in_req_t in_data,
    output logic                   stage_valid,
    input  wire logic              stage_ready,
    output lptr_pkg::stage_t       stage_data
);
    import lptr_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    stage_t            s1_reg;
    stage_t            s1_next;
    logic [LOSS_W-1:0] prev_loss_reg;
    logic              prev_valid_reg;
    logic              accept;
    logic              loss_up;

    assign in_ready    = !s1_valid_reg || stage_ready;
    assign accept      = in_valid && in_ready;
    assign stage_valid = s1_valid_reg;
    assign stage_data  = s1_reg;

    assign loss_up = in_data.loss > prev_loss_reg;

    always_comb
    begin
        s1_next.abs_change = loss_up ? (in_data.loss - prev_loss_reg)
                                     : (prev_loss_reg - in_data.loss);
        s1_next.velocity   = prev_valid_reg
                             ? ({1'b0, prev_loss_reg} - {1'b0, in_data.loss})
                             : '0;
        s1_next.falling    = prev_valid_reg && (prev_loss_reg > in_data.loss);
        s1_next.first      = !prev_valid_reg;
        s1_next.direction  = in_data.direction;
        s1_valid_next      = accept || (s1_valid_reg && !stage_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            prev_loss_reg  <= '0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                prev_loss_reg  <= in_data.loss;
                prev_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lptr_core.sv @@
// recurrence stage: change average, radius, stuck counter, result register
`default_nettype none

module lptr_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lptr_pkg::cfg_t    cfg,
    input  wire logic              stage_valid,
    output logic                   stage_ready,
    input  wire lptr_pkg::stage_t  stage_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lptr_pkg::out_req_t     out_data
);
    import lptr_pkg::*;

    logic                out_valid_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [RADIUS_W-1:0] radius_next;
    logic                flag_reg;
    logic                flag_next;
    logic [COUNT_W-1:0]  steps_reg;
    logic [COUNT_W-1:0]  steps_next;
    logic [LOSS_W-1:0]   avg_reg;
    logic [LOSS_W-1:0]   avg_next;
    logic [VEL_W-1:0]    vel_reg;
    logic [DIR_W-1:0]    dir_reg;

    logic                advance;
    logic signed [32:0]  delta;
    logic                delta_neg;
    logic [31:0]         delta_mag;
    logic [63:0]         recip_prod;
    logic [28:0]         delta_q;
    logic [LOSS_W-1:0]   avg_step;
    logic [COUNT_W-1:0]  steps_inc;
    logic [31:0]         shrink_prod;
    logic [RADIUS_W-1:0] radius_shrunk;

    assign stage_ready = !out_valid_reg || out_ready;
    assign advance     = stage_valid && stage_ready;

    // avg' = floor((9*avg + d + 5) / 10) = avg + floor((d + 5 - avg) / 10)
    assign delta     = $signed({2'b00, stage_data.abs_change}) + 33'sd5
                     - $signed({2'b00, avg_reg});
    assign delta_neg = delta[32];
    // floor of a negative quotient: -floor((9 - delta) / 10)
    assign delta_mag = delta_neg ? 32'(33'sd9 - delta) : delta[31:0];
    // divide by ten through the reciprocal, exact for any 32-bit dividend
    assign recip_prod = 64'(delta_mag) * 64'h0000_0000_CCCC_CCCD;
    assign delta_q    = recip_prod[63:35];
    assign avg_step   = delta_neg ? (avg_reg - LOSS_W'(delta_q))
                                  : (avg_reg + LOSS_W'(delta_q));

    assign steps_inc     = (steps_reg == COUNT_MAX) ? COUNT_MAX : (steps_reg + 16'd1);
    assign shrink_prod   = 32'(radius_reg) * 32'(cfg.shrink_factor) + 32'd32768;
    assign radius_shrunk = shrink_prod[31:16];

    always_comb
    begin
        avg_next    = stage_data.first ? avg_reg : avg_step;
        radius_next = radius_reg;
        flag_next   = flag_reg;
        steps_next  = steps_inc;
        priority if (avg_next < cfg.flat_threshold)
        begin
            flag_next   = 1'b0;
            steps_next  = '0;
            radius_next = RADIUS_ONE;
        end
        else if (stage_data.falling)
        begin
            flag_next   = 1'b1;
            radius_next = radius_shrunk;
        end
        else if (steps_inc > cfg.stuck_limit)
        begin
            flag_next   = 1'b1;
            radius_next = RADIUS_KICK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            radius_reg    <= RADIUS_ONE;
            flag_reg      <= 1'b0;
            steps_reg     <= '0;
            avg_reg       <= '0;
            vel_reg       <= '0;
            dir_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                radius_reg    <= radius_next;
                flag_reg      <= flag_next;
                steps_reg     <= steps_next;
                avg_reg       <= avg_next;
                vel_reg       <= stage_data.velocity;
                dir_reg       <= stage_data.direction;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid                  = out_valid_reg;
    assign out_data.radius            = radius_reg;
    assign out_data.ravine_flag       = flag_reg;
    assign out_data.stuck_count       = steps_reg;
    assign out_data.velocity          = vel_reg;
    assign out_data.change_average    = avg_reg;
    assign out_data.latched_direction = dir_reg;

    // a cleared counter only comes from reset or a flat region
    a_zero_count_calm: assert property (@(posedge clk) disable iff (!rst_n)
        (steps_reg == '0) |-> (!flag_reg && radius_reg == RADIUS_ONE))
        else $error("zero stuck count with flag or radius set");

    // the radius leaves 1.0 only together with the ravine flag
    a_flag_radius: assert property (@(posedge clk) disable iff (!rst_n)
        !flag_reg |-> (radius_reg == RADIUS_ONE))
        else $error("radius moved without ravine flag");

    // the first sample reports no velocity and keeps the average
    a_first_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_data.first) |=> (vel_reg == '0 && $stable(avg_reg)))
        else $error("first sample changed velocity or average");

    // every request taken from the front stage shows up as a result
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register missed a request");

endmodule

`default_nettype wire

@@ hdl/loss_plateau_ravine_tracker.sv @@
// top level of the loss plateau and ravine tracker
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  input    | in_valid / in_ready     | in_data: loss (Q7.24), direction (Q3.13)
//  output   | out_valid / out_ready   | out_data: radius, ravine_flag, stuck_count,
//           |                         |   velocity, change_average, latched_direction
//  config   | psel / penable / pready | paddr, pwdata, prdata (32 bit)
//
// one request per cycle sustained while out_ready stays high; the input register
//   loads at the accepting edge and the result register takes the request from it
//   once stage_ready is high, which raises out_valid
// the per-cycle limit is the change average loop: subtract, reciprocal divide
//   by ten, add and threshold compare all sit between the two registers
// reset (rst_n low) clears the previous loss, the average, the counter and the
//   flag, sets the radius to 1.0 and loads the register defaults
// a stalled output holds its result; the input register still takes one more
//   request behind it, then in_ready drops until out_ready returns
`default_nettype none

module loss_plateau_ravine_tracker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire lptr_pkg::in_req_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output lptr_pkg::out_req_t               out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lptr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lptr_pkg::DATA_W-1:0] pwdata,
    output logic      [lptr_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import lptr_pkg::*;

    // live configuration; the user must write it only while no request is in flight, the block does not enforce it
    cfg_t   cfg;

    // front stage to recurrence stage
    logic   stage_valid;
    logic   stage_ready;
    stage_t stage_data;

    // register file: flat threshold, stuck limit, shrink factor
    lptr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // absolute loss change, velocity and falling flag against the previous sample
    lptr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage_data  (stage_data)
    );

    // average update, flat / falling / stuck decision and the result register
    lptr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage_data  (stage_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
